FILE: src/assert_macros.svh
// Assertion macros used by the top level of the I2C master bit sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an antecedent implies a consequent in the same cycle.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Checks that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/i2cms_pkg.sv
// Package with the types, constants and functions of the I2C master bit sequencer.
package i2cms_pkg;

   typedef enum logic [2:0] {
      MODE_START = 3'd0,
      MODE_STOP  = 3'd1,
      MODE_SEND  = 3'd2,
      MODE_RECV  = 3'd3,
      MODE_SACK  = 3'd4,
      MODE_RACK  = 3'd5
   } mode_type;

   localparam int QUEUE_DEPTH = 2;
   localparam int PHASE_W     = 5;

   typedef struct packed {
      logic       take;
      mode_type   mode;
      logic [7:0] tx_byte;
      logic       ack_bit;
      logic       sda_in;
   } queue_entry_type;

   function automatic logic [PHASE_W-1:0] cmd_len(input mode_type m);
      logic [PHASE_W-1:0] len;
      unique case (m)
         MODE_START: len = PHASE_W'(3);
         MODE_STOP:  len = PHASE_W'(3);
         MODE_SEND:  len = PHASE_W'(24);
         MODE_RECV:  len = PHASE_W'(17);
         MODE_SACK:  len = PHASE_W'(2);
         MODE_RACK:  len = PHASE_W'(3);
         default:    len = PHASE_W'(1);
      endcase
      return len;
   endfunction

endpackage

FILE: src/i2cms_req_if.sv
// Channel that carries one tick item with its optional command into the sequencer.
interface i2cms_req_if;
   logic       valid;
   logic       ready;
   logic       cmd_valid;
   logic [2:0] mode;
   logic [7:0] tx_byte;
   logic       ack_bit;
   logic       sda_in;

   modport source (output valid, cmd_valid, mode, tx_byte, ack_bit, sda_in, input ready);
   modport sink (input valid, cmd_valid, mode, tx_byte, ack_bit, sda_in, output ready);
endinterface

FILE: src/i2cms_rsp_if.sv
// Channel that carries one line-level result item out of the sequencer.
interface i2cms_rsp_if;
   logic       valid;
   logic       ready;
   logic       scl_out;
   logic       sda_out;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_seen;

   modport source (output valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                   input ready);
   modport sink (input valid, scl_out, sda_out, busy_res, done_res, rx_byte, ack_seen,
                 output ready);
endinterface

FILE: src/i2cms_front.sv
// Front end: accepts tick items, classifies their commands and queues them.
module i2cms_front (
   input  logic                       clock,
   input  logic                       reset,
   i2cms_req_if.sink                  req,
   output logic                       queue_valid,
   output i2cms_pkg::queue_entry_type queue_head,
   input  logic                       queue_pop
);
   import i2cms_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type entry_ff [QUEUE_DEPTH];
   queue_entry_type new_entry;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             legal_mode;

   assign legal_mode = (req.mode <= 3'(MODE_RACK));

   always_comb begin
      new_entry.take    = req.cmd_valid && legal_mode;
      new_entry.mode    = legal_mode ? mode_type'(req.mode) : MODE_START;
      new_entry.tx_byte = req.tx_byte;
      new_entry.ack_bit = req.ack_bit;
      new_entry.sda_in  = req.sda_in;
   end

   assign req.ready   = (count_ff < CNT_W'(QUEUE_DEPTH));
   assign push        = req.valid && req.ready;
   assign queue_valid = (count_ff != '0);
   assign queue_head  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (queue_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !queue_pop) begin
         count_in = count_ff + 1'b1;
      end else if (queue_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

FILE: src/i2cms_back.sv
// Back end: steps the bus line sequence one period per queued tick and registers the result.
module i2cms_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_valid,
   input  i2cms_pkg::queue_entry_type queue_head,
   output logic                       queue_pop,
   i2cms_rsp_if.source                rsp
);
   import i2cms_pkg::*;

   logic               active_ff, active_in;
   mode_type           mode_ff, mode_in;
   logic [PHASE_W-1:0] phase_ff, phase_in;
   logic [1:0]         sub_ff, sub_in;
   logic [7:0]         shift_out_ff, shift_out_in;
   logic [7:0]         shift_in_ff, shift_in_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic               ack_ff, ack_in;
   logic               done;

   logic               take_cmd;
   logic               cur_active;
   mode_type           cur_mode;
   logic [PHASE_W-1:0] cur_phase;
   logic [PHASE_W-1:0] phase_next;

   logic               rsp_valid_ff;
   logic               rsp_scl_ff;
   logic               rsp_sda_ff;
   logic               rsp_busy_ff;
   logic               rsp_done_ff;
   logic [7:0]         rsp_rx_ff;
   logic               rsp_ack_ff;

   assign queue_pop  = queue_valid && (!rsp_valid_ff || rsp.ready);
   assign take_cmd   = !active_ff && queue_head.take;
   assign cur_active = active_ff || take_cmd;
   assign cur_mode   = take_cmd ? queue_head.mode : mode_ff;
   assign cur_phase  = take_cmd ? '0 : phase_ff;
   assign phase_next = cur_phase + 1'b1;

   // Sequencing of the command: active flag, mode, period and bit sub-phase.
   always_comb begin
      active_in = cur_active;
      mode_in   = cur_mode;
      phase_in  = cur_phase;
      sub_in    = take_cmd ? 2'd0 : sub_ff;
      done      = 1'b0;
      if (cur_active) begin
         sub_in = (sub_in == 2'd2) ? 2'd0 : sub_in + 1'b1;
         if (phase_next >= cmd_len(cur_mode)) begin
            active_in = 1'b0;
            phase_in  = '0;
            done      = 1'b1;
         end else begin
            phase_in = phase_next;
         end
      end
   end

   // Line levels and shift registers for the current period.
   always_comb begin
      logic [1:0] sub_cur;
      logic [2:0] bit_sel;
      sub_cur      = take_cmd ? 2'd0 : sub_ff;
      bit_sel      = 3'(cur_phase[PHASE_W-1:1] - 1'b1);
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      ack_in       = ack_ff;
      shift_out_in = shift_out_ff;
      shift_in_in  = shift_in_ff;
      if (take_cmd && (queue_head.mode == MODE_SEND)) begin
         shift_out_in = queue_head.tx_byte;
      end
      if (take_cmd && (queue_head.mode == MODE_RECV)) begin
         shift_in_in = '0;
      end
      if (cur_active) begin
         unique case (cur_mode)
            MODE_START: begin
               if (cur_phase == PHASE_W'(0)) begin
                  scl_in = 1'b1;
                  sda_in = 1'b1;
               end else if (cur_phase == PHASE_W'(1)) begin
                  sda_in = 1'b0;
               end else begin
                  scl_in = 1'b0;
               end
            end
            MODE_STOP: begin
               if (cur_phase == PHASE_W'(0)) begin
                  sda_in = 1'b0;
               end else if (cur_phase == PHASE_W'(1)) begin
                  scl_in = 1'b1;
               end else begin
                  sda_in = 1'b1;
               end
            end
            MODE_SEND: begin
               if (sub_cur == 2'd0) begin
                  sda_in = shift_out_in[7];
               end else if (sub_cur == 2'd1) begin
                  scl_in = 1'b1;
               end else begin
                  scl_in       = 1'b0;
                  shift_out_in = {shift_out_in[6:0], 1'b0};
               end
            end
            MODE_RECV: begin
               if (cur_phase == PHASE_W'(0)) begin
                  sda_in = 1'b1;
               end else if (cur_phase[0]) begin
                  scl_in = 1'b1;
               end else begin
                  if (queue_head.sda_in) begin
                     shift_in_in[3'd7 - bit_sel] = 1'b1;
                  end
                  scl_in = 1'b0;
               end
            end
            MODE_SACK: begin
               if (cur_phase == PHASE_W'(0)) begin
                  sda_in = queue_head.ack_bit;
                  scl_in = 1'b1;
               end else begin
                  scl_in = 1'b0;
               end
            end
            MODE_RACK: begin
               if (cur_phase == PHASE_W'(0)) begin
                  sda_in = 1'b1;
               end else if (cur_phase == PHASE_W'(1)) begin
                  scl_in = 1'b1;
               end else begin
                  ack_in = queue_head.sda_in;
                  scl_in = 1'b0;
               end
            end
            default: begin
               scl_in = scl_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         mode_ff      <= MODE_START;
         phase_ff     <= '0;
         sub_ff       <= 2'd0;
         shift_out_ff <= '0;
         shift_in_ff  <= '0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         ack_ff       <= 1'b1;
      end else if (queue_pop) begin
         active_ff    <= active_in;
         mode_ff      <= mode_in;
         phase_ff     <= phase_in;
         sub_ff       <= sub_in;
         shift_out_ff <= shift_out_in;
         shift_in_ff  <= shift_in_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         ack_ff       <= ack_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (queue_pop) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         rsp_scl_ff  <= scl_in;
         rsp_sda_ff  <= sda_in;
         rsp_busy_ff <= active_in;
         rsp_done_ff <= done;
         rsp_rx_ff   <= shift_in_in;
         rsp_ack_ff  <= ack_in;
      end
   end

   assign rsp.valid    = rsp_valid_ff;
   assign rsp.scl_out  = rsp_scl_ff;
   assign rsp.sda_out  = rsp_sda_ff;
   assign rsp.busy_res = rsp_busy_ff;
   assign rsp.done_res = rsp_done_ff;
   assign rsp.rx_byte  = rsp_rx_ff;
   assign rsp.ack_seen = rsp_ack_ff;

endmodule

FILE: src/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: front queue and back sequencer.
//
// Each item on req is one bus delay period (a tick). A tick may carry a
// command (start, stop, send byte, receive byte, send ack, receive ack),
// which is taken only when no command is in progress; the taking tick is
// already the first period of the command. Every tick yields exactly one
// item on rsp with the SCL and SDA levels to hold for that period, the busy
// and done flags, the receive byte and the last sampled acknowledge.
// The front part queues up to two ticks; the back part steps one period per
// cycle while rsp is ready and holds its result in an output register. An
// accepted tick is written into the queue, popped by the back part and then
// held in the result register that drives rsp.valid, and one item per cycle
// is sustained while rsp is ready. When rsp stalls, the result register
// holds, the queue fills, and req.ready drops once two ticks are waiting.
// Reset is synchronous and active high: the queue empties, the sequencer
// goes idle, and both lines read as released (high) with no result pending.
module i2c_master_bit_sequencer (
   input logic         clock,
   input logic         reset,
   i2cms_req_if.sink   req,
   i2cms_rsp_if.source rsp
);
   import i2cms_pkg::*;
`include "assert_macros.svh"

   logic            queue_valid;
   queue_entry_type queue_head;
   logic            queue_pop;

   i2cms_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req),
      .queue_valid (queue_valid),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop)
   );

   i2cms_back u_back (
      .clock       (clock),
      .reset       (reset),
      .queue_valid (queue_valid),
      .queue_head  (queue_head),
      .queue_pop   (queue_pop),
      .rsp         (rsp)
   );

   `ASSERT_SAME_CYCLE(a_pop_needs_entry, clock, reset, queue_pop, queue_valid, "pop from empty queue")
   `ASSERT_SAME_CYCLE(a_full_has_entry, clock, reset, !req.ready, queue_valid, "queue full yet empty")
   `ASSERT_SAME_CYCLE(a_done_not_busy, clock, reset, rsp.valid && rsp.done_res, !rsp.busy_res, "done while busy")
   `ASSERT_NEXT_CYCLE(a_pop_gives_rsp, clock, reset, queue_pop, rsp.valid, "popped tick gave no item")

endmodule
